[rtl/core/lss_pkg.sv]
// Shared types and constants of the laser scan segmenter.
package lss_pkg;

  localparam int IDX_IN_BITS = 10;
  localparam int RANGE_BITS  = 16;
  localparam int CNT_BITS    = 10;
  localparam int SIZE_BITS   = 34;
  localparam int PCT_BITS    = 7;

  localparam logic [6:0] PCT_FULL = 7'd100;

  localparam logic [2:0] REG_MOTION_THR = 3'd0;
  localparam logic [2:0] REG_GAP        = 3'd1;
  localparam logic [2:0] REG_LEG_MIN    = 3'd2;
  localparam logic [2:0] REG_LEG_MAX    = 3'd3;
  localparam logic [2:0] REG_PCT_LIMIT  = 3'd4;

  localparam logic [15:0] RST_MOTION_THR = 16'd200;
  localparam logic [15:0] RST_GAP        = 16'd200;
  localparam logic [15:0] RST_LEG_MIN    = 16'd50;
  localparam logic [15:0] RST_LEG_MAX    = 16'd250;
  localparam logic [6:0]  RST_PCT_LIMIT  = 7'd75;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_IDX, S_READ, S_MARK, S_DECIDE,
    S_EM_MUL, S_EM_DIV, S_EM_OUT, S_UPDATE
  } lss_state_t;

  typedef struct packed {
    logic [15:0] motion_thr;
    logic [15:0] gap;
    logic [15:0] leg_min;
    logic [15:0] leg_max;
    logic [6:0]  pct_limit;
  } lss_cfg_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic idx_calc;
    logic mem_rd;
    logic mark;
    logic decide;
    logic em_mul;
    logic div_step;
    logic out_load;
    logic em_last;
    logic update;
  } lss_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic gap_hit;
    logic last;
    logic div_done;
    logic out_free;
  } lss_stat_t;

endpackage

[rtl/core/lss_cfg.sv]
// Configuration register file behind the APB-style port.
module lss_cfg import lss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lss_cfg_t    cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motion_thr <= RST_MOTION_THR;
      cfg.gap        <= RST_GAP;
      cfg.leg_min    <= RST_LEG_MIN;
      cfg.leg_max    <= RST_LEG_MAX;
      cfg.pct_limit  <= RST_PCT_LIMIT;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MOTION_THR: cfg.motion_thr <= pwdata[15:0];
        REG_GAP:        cfg.gap        <= pwdata[15:0];
        REG_LEG_MIN:    cfg.leg_min    <= pwdata[15:0];
        REG_LEG_MAX:    cfg.leg_max    <= pwdata[15:0];
        REG_PCT_LIMIT:  cfg.pct_limit  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MOTION_THR: prdata = {16'd0, cfg.motion_thr};
      REG_GAP:        prdata = {16'd0, cfg.gap};
      REG_LEG_MIN:    prdata = {16'd0, cfg.leg_min};
      REG_LEG_MAX:    prdata = {16'd0, cfg.leg_max};
      REG_PCT_LIMIT:  prdata = {25'd0, cfg.pct_limit};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/lss_ctrl.sv]
// Sequencing state machine of the segmenter.
module lss_ctrl import lss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lss_stat_t stat,
  output lss_cmd_t  cmd
);

  lss_state_t state, state_next;
  logic       em_last, em_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      em_last <= 1'b0;
    end else begin
      state   <= state_next;
      em_last <= em_last_next;
    end
  end

  always_comb begin
    state_next   = state;
    em_last_next = em_last;
    case (state)
      S_CLEAR:  if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_IDX;
      S_IDX:    state_next = S_READ;
      S_READ:   state_next = S_MARK;
      S_MARK:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.gap_hit) begin
          state_next   = S_EM_MUL;
          em_last_next = 1'b0;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (stat.last) begin
          state_next   = S_EM_MUL;
          em_last_next = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EM_MUL: state_next = S_EM_DIV;
      S_EM_DIV: if (stat.div_done) state_next = S_EM_OUT;
      S_EM_OUT: begin
        if (stat.out_free) state_next = em_last ? S_IDLE : S_UPDATE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.em_last  = em_last;
    in_ready     = (state == S_IDLE);
    case (state)
      S_CLEAR:  cmd.clear    = 1'b1;
      S_IDLE:   cmd.accept   = in_valid;
      S_IDX:    cmd.idx_calc = 1'b1;
      S_READ:   cmd.mem_rd   = 1'b1;
      S_MARK:   cmd.mark     = 1'b1;
      S_DECIDE: cmd.decide   = 1'b1;
      S_UPDATE: cmd.update   = 1'b1;
      S_EM_MUL: cmd.em_mul   = 1'b1;
      S_EM_DIV: cmd.div_step = !stat.div_done;
      S_EM_OUT: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

  a_accept_to_idx: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_IDX))
    else $error("accepted request did not start index stage");

  a_emit_return: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_OUT && stat.out_free) |=> (state == S_IDLE || state == S_UPDATE))
    else $error("emission did not return to update or idle");

endmodule

[rtl/core/lss_dp.sv]
// Datapath: stores, cluster state, squared distances, percentage divider, output register.
module lss_dp import lss_pkg::*; #(
  parameter int MAX_BEAMS  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lss_cmd_t                     cmd,
  output lss_stat_t                    stat,
  input  lss_cfg_t                     cfg,
  input  logic [IDX_IN_BITS-1:0]       in_beam_index,
  input  logic [RANGE_BITS-1:0]        in_range,
  input  logic [COORD_BITS-1:0]        in_x,
  input  logic [COORD_BITS-1:0]        in_y,
  input  logic                         in_moving,
  input  logic                         in_last,
  output logic [CNT_BITS-1:0]          out_cnum,
  output logic [SIZE_BITS-1:0]         out_size,
  output logic [COORD_BITS-1:0]        out_mx,
  output logic [COORD_BITS-1:0]        out_my,
  output logic [PCT_BITS-1:0]          out_pct,
  output logic                         out_leg,
  output logic                         out_leg_moving,
  output logic                         out_last,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int IW    = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
  localparam int HW    = IW + 1;
  localparam int DHW   = IW + 2;
  localparam int NW    = DHW + 7;
  localparam int CW    = COORD_BITS + 1;
  localparam int DW    = 2 * CW;
  localparam int EW    = (DW > SIZE_BITS) ? DW : SIZE_BITS;
  localparam int GW    = (DW > 32) ? DW : 32;
  localparam int RSH   = 20;
  localparam int RW    = RSH + 1;
  localparam int RECIP = ((1 << RSH) + MAX_BEAMS - 1) / MAX_BEAMS;
  localparam int PW    = IDX_IN_BITS + RW;
  localparam int DCW   = $clog2(NW + 1);
  localparam logic [EW-1:0] SIZE_SAT = EW'({SIZE_BITS{1'b1}});

  // stores
  logic [RANGE_BITS-1:0]   bg_mem [MAX_BEAMS];
  logic                    mark_mem [MAX_BEAMS];
  logic [2*COORD_BITS-1:0] pt_mem [MAX_BEAMS];

  // item registers
  logic [IDX_IN_BITS-1:0] raw_idx;
  logic [IDX_IN_BITS-1:0] q_r;
  logic [IW-1:0]          idx_r;
  logic [RANGE_BITS-1:0]  range_r;
  logic [COORD_BITS-1:0]  x_r, y_r;
  logic                   moving_r, last_r, capture_r;
  logic [RANGE_BITS-1:0]  bg_rd;
  logic                   mark_rd, mark_r;
  logic [DW-1:0]          gsa, gsb;
  logic [31:0]            g2_r;
  logic                   restart_r, gap_r;

  // scan state
  logic                   was_moving, fresh;
  logic [COORD_BITS-1:0]  prev_x, prev_y, start_x, start_y;
  logic [IW-1:0]          start_idx;
  logic [DHW-1:0]         dyn;
  logic [CNT_BITS-1:0]    cnt;
  logic [IW-1:0]          clr_addr;

  // emission registers
  logic [DW-1:0]          esa, esb;
  logic [31:0]            lo_r, hi_r;
  logic [HW-1:0]          hits_r, rem;
  logic [NW-1:0]          quo;
  logic [DCW-1:0]         dcnt;
  logic [2*COORD_BITS-1:0] sp_rd;

  // combinational
  logic [PW-1:0]          qprod;
  logic [31:0]            qm;
  logic [RANGE_BITS-1:0]  bg_val, bdiff;
  logic                   mark_new;
  logic signed [CW-1:0]   gdx, gdy, edx, edy;
  logic signed [DW-1:0]   gpx, gpy, epx, epy;
  logic [GW-1:0]          gsum;
  logic                   restart_now;
  logic [IW-1:0]          end_idx, span, mid;
  logic                   in_order;
  logic [HW-1:0]          hits;
  logic [HW:0]            rem_sh;
  logic [EW-1:0]          d2;
  logic                   leg;
  logic [PCT_BITS-1:0]    pct;
  logic                   mk_we;
  logic [IW-1:0]          mk_addr;
  logic [DHW-1:0]         dyn_base;

  assign qprod = PW'(in_beam_index) * PW'(RECIP);
  assign qm    = 32'(q_r) * 32'(MAX_BEAMS);

  assign bg_val   = capture_r ? range_r : bg_rd;
  assign bdiff    = (bg_val > range_r) ? bg_val - range_r : range_r - bg_val;
  assign mark_new = moving_r ? mark_rd : (bdiff > cfg.motion_thr);

  assign gdx = $signed({prev_x[COORD_BITS-1], prev_x}) - $signed({x_r[COORD_BITS-1], x_r});
  assign gdy = $signed({prev_y[COORD_BITS-1], prev_y}) - $signed({y_r[COORD_BITS-1], y_r});
  assign gpx = gdx * gdx;
  assign gpy = gdy * gdy;
  assign gsum = GW'(gsa) + GW'(gsb);
  assign restart_now = fresh || (idx_r == '0);

  assign edx = $signed({start_x[COORD_BITS-1], start_x}) -
               $signed({prev_x[COORD_BITS-1], prev_x});
  assign edy = $signed({start_y[COORD_BITS-1], start_y}) -
               $signed({prev_y[COORD_BITS-1], prev_y});
  assign epx = edx * edx;
  assign epy = edy * edy;

  // end of the closing cluster: previous beam on a gap, this beam on the last beam
  assign end_idx  = cmd.em_last ? idx_r : idx_r - 1'b1;
  assign in_order = (end_idx >= start_idx);
  assign span     = end_idx - start_idx;
  assign hits     = in_order ? HW'(span) + 1'b1 : HW'(1);
  assign mid      = in_order ? end_idx - (span >> 1) : end_idx;

  assign rem_sh = {rem, quo[NW-1]};

  assign d2  = EW'(esa) + EW'(esb);
  assign leg = (d2 > EW'(lo_r)) && (d2 < EW'(hi_r));
  assign pct = (quo > NW'(PCT_FULL)) ? PCT_FULL : quo[PCT_BITS-1:0];

  assign mk_we   = cmd.clear || (cmd.mark && !moving_r);
  assign mk_addr = cmd.clear ? clr_addr : idx_r;
  assign dyn_base = (restart_r || gap_r) ? '0 : dyn;

  assign stat.clear_done = (clr_addr == IW'(MAX_BEAMS - 1));
  assign stat.gap_hit    = !restart_now && (gsum > GW'(g2_r));
  assign stat.last       = last_r;
  assign stat.div_done   = (dcnt == '0);
  assign stat.out_free   = !out_valid || out_ready;

  // background store: capture write and read in the read stage
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      if (capture_r) bg_mem[idx_r] <= range_r;
      bg_rd <= bg_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mk_we) mark_mem[mk_addr] <= cmd.clear ? 1'b0 : mark_new;
    if (cmd.mem_rd) mark_rd <= mark_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) pt_mem[idx_r] <= {y_r, x_r};
    if (cmd.em_mul) sp_rd <= pt_mem[mid];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear && !stat.clear_done) clr_addr <= clr_addr + 1'b1;
  end

  // item stages
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      raw_idx  <= in_beam_index;
      q_r      <= qprod[RSH +: IDX_IN_BITS];
      range_r  <= in_range;
      x_r      <= in_x;
      y_r      <= in_y;
      moving_r <= in_moving;
      last_r   <= in_last;
    end
    if (cmd.idx_calc) begin
      idx_r     <= IW'(32'(raw_idx) - qm);
      capture_r <= !moving_r && was_moving;
    end
    if (cmd.mark) begin
      mark_r <= mark_new;
      gsa    <= DW'(gpx);
      gsb    <= DW'(gpy);
      g2_r   <= cfg.gap * cfg.gap;
    end
    if (cmd.decide) begin
      restart_r <= restart_now;
      gap_r     <= stat.gap_hit;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      was_moving <= 1'b1;
      fresh      <= 1'b1;
      prev_x     <= '0;
      prev_y     <= '0;
      start_x    <= '0;
      start_y    <= '0;
      start_idx  <= '0;
      dyn        <= '0;
      cnt        <= '0;
    end else begin
      if (cmd.update) begin
        if (restart_r || gap_r) begin
          start_idx <= idx_r;
          start_x   <= x_r;
          start_y   <= y_r;
        end
        if (restart_r) begin
          cnt   <= '0;
          fresh <= 1'b0;
        end
        if (dyn_base != '1) dyn <= dyn_base + DHW'(mark_r);
        else                dyn <= dyn_base;
        prev_x <= x_r;
        prev_y <= y_r;
      end
      if (cmd.out_load) begin
        if (cmd.em_last) begin
          fresh      <= 1'b1;
          dyn        <= '0;
          cnt        <= '0;
          was_moving <= moving_r;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // emission: squares, limits and restoring divider
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.em_mul) begin
      dcnt <= DCW'(NW);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_mul) begin
      esa    <= DW'(epx);
      esb    <= DW'(epy);
      lo_r   <= cfg.leg_min * cfg.leg_min;
      hi_r   <= cfg.leg_max * cfg.leg_max;
      hits_r <= hits;
      rem    <= '0;
      quo    <= NW'(dyn) * NW'(PCT_FULL);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, hits_r}) begin
        rem <= HW'(rem_sh - {1'b0, hits_r});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[HW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cnum       <= cnt;
      out_size       <= (d2 > SIZE_SAT) ? {SIZE_BITS{1'b1}} : d2[SIZE_BITS-1:0];
      out_mx         <= sp_rd[COORD_BITS-1:0];
      out_my         <= sp_rd[2*COORD_BITS-1:COORD_BITS];
      out_pct        <= pct;
      out_leg        <= leg;
      out_leg_moving <= leg && (pct > cfg.pct_limit);
      out_last       <= cmd.em_last;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

[rtl/core/laser_scan_segmenter_unit.sv]
// Laser scan segmenter: beams in, closed clusters out.
// Sequence: each beam is accepted in idle, then passes the index, read, mark, decide and
// update states; a beam that closes a cluster (on a gap, or the last beam) also runs the
// multiply state, the bit-serial percentage divider and the output state, which waits while
// the output register holds an untaken result. One beam at a time through the sequencer.
// Reset (rst, synchronous): the marks are cleared entry by entry; requests wait, writes do not.
module laser_scan_segmenter_unit import lss_pkg::*; #(
  parameter int MAX_BEAMS  = 1024,
  parameter int COORD_BITS = 16,
  localparam int S_DW = ((IDX_IN_BITS + RANGE_BITS + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int M_DW = ((CNT_BITS + SIZE_BITS + 2 * COORD_BITS + PCT_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // beam_index, range_mm, point_x_mm, point_y_mm (lowest first)
  input  logic [S_DW-1:0] s_tdata,
  // moving flag
  input  logic            s_tuser,
  input  logic            s_tlast,
  output logic            m_tvalid,
  input  logic            m_tready,
  // cluster_number, size_squared_mm2, middle_x_mm, middle_y_mm, dynamic_percent
  output logic [M_DW-1:0] m_tdata,
  // is_leg, leg_moving (lowest first)
  output logic [1:0]      m_tuser,
  output logic            m_tlast,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int C = COORD_BITS;

  lss_cfg_t  cfg;
  lss_cmd_t  cmd;
  lss_stat_t stat;

  logic [CNT_BITS-1:0]  o_cnum;
  logic [SIZE_BITS-1:0] o_size;
  logic [C-1:0]         o_mx, o_my;
  logic [PCT_BITS-1:0]  o_pct;
  logic                 o_leg, o_lm;

  // register file
  lss_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // sequencer
  lss_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .stat, .cmd
  );

  // stores, arithmetic and output register; fields unpacked from tdata
  lss_dp #(.MAX_BEAMS(MAX_BEAMS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg,
    .in_beam_index(s_tdata[IDX_IN_BITS-1:0]),
    .in_range(s_tdata[IDX_IN_BITS +: RANGE_BITS]),
    .in_x(s_tdata[IDX_IN_BITS + RANGE_BITS +: C]),
    .in_y(s_tdata[IDX_IN_BITS + RANGE_BITS + C +: C]),
    .in_moving(s_tuser),
    .in_last(s_tlast),
    .out_cnum(o_cnum),
    .out_size(o_size),
    .out_mx(o_mx),
    .out_my(o_my),
    .out_pct(o_pct),
    .out_leg(o_leg),
    .out_leg_moving(o_lm),
    .out_last(m_tlast),
    .out_valid(m_tvalid),
    .out_ready(m_tready)
  );

  assign m_tdata = M_DW'({o_pct, o_my, o_mx, o_size, o_cnum});
  assign m_tuser = {o_lm, o_leg};

endmodule
